### design/interrupt_dispatch_accounting_macros.svh
// ----------------------------------------------------------------------------
// Interrupt dispatch accounting assertion macros
// Shared concurrent assertion forms used by the block's checker.
// ----------------------------------------------------------------------------
`ifndef INTERRUPT_DISPATCH_ACCOUNTING_MACROS_SVH
`define INTERRUPT_DISPATCH_ACCOUNTING_MACROS_SVH

// same-cycle implication
`define IDAC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IDAC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/idac_pkg.sv
// ----------------------------------------------------------------------------
// Interrupt dispatch accounting package
// Item types, per-line row layout, op and outcome codes, latency constants.
// ----------------------------------------------------------------------------
package idac_pkg;

	localparam int LINE_COUNT = 256;
	localparam int IDX_W      = $clog2(LINE_COUNT);
	localparam int LINE_W     = 10;
	localparam int ACK_W      = 13;

	localparam logic [2:0] OP_REGISTER = 3'd0;
	localparam logic [2:0] OP_ENABLE   = 3'd1;
	localparam logic [2:0] OP_DISABLE  = 3'd2;
	localparam logic [2:0] OP_DISPATCH = 3'd3;
	localparam logic [2:0] OP_QUERY    = 3'd4;

	localparam logic [1:0] OUT_NONE      = 2'd0;
	localparam logic [1:0] OUT_HANDLED   = 2'd1;
	localparam logic [1:0] OUT_UNHANDLED = 2'd2;
	localparam logic [1:0] OUT_SPURIOUS  = 2'd3;

	localparam logic [LINE_W-1:0] SPURIOUS_FIRST    = 10'd1020;
	localparam logic [LINE_W-1:0] FIRST_REGISTRABLE = 10'd16;
	localparam logic [LINE_W-1:0] LINE_LIMIT        = LINE_W'(LINE_COUNT);
	localparam logic [7:0]        PRIORITY_RESET    = 8'hA0;

	// us = ((cycles * 64 + 395) mod 2^32) / 396 = (x >> 2) / 99
	localparam int          LAT_SCALE_SHIFT = 6;
	localparam logic [31:0] LAT_BIAS        = 32'd395;
	localparam int          LAT_PRE_SHIFT   = 2;
	localparam int          LAT_DIVISOR     = 99;
	localparam int          LAT_Y_W         = 32 - LAT_PRE_SHIFT;
	localparam int          LAT_RECIP_SHIFT = 37;
	localparam logic [31:0] LAT_RECIP =
		32'(((64'd1 << LAT_RECIP_SHIFT) + 64'(LAT_DIVISOR - 1)) / 64'(LAT_DIVISOR));

	typedef struct packed {
		logic [2:0]        op;
		logic [LINE_W-1:0] line;
		logic              handler_valid;
		logic [7:0]        priority_req;
		logic [ACK_W-1:0]  acknowledge;
		logic [31:0]       elapsed_cycles;
	} in_item_t;

	typedef struct packed {
		logic              accepted;
		logic [1:0]        outcome;
		logic [LINE_W-1:0] line_out;
		logic [ACK_W-1:0]  eoi_word;
		logic              line_enabled_out;
		logic [7:0]        priority_out;
		logic [31:0]       handled_total;
		logic [31:0]       unhandled_total;
		logic [31:0]       spurious_total;
		logic [31:0]       worst_latency_us;
	} out_item_t;

	typedef struct packed {
		logic        present;
		logic        enable;
		logic [7:0]  prio;
		logic [31:0] count;
	} row_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		row_t             row;
	} row_wr_t;

	localparam row_t ROW_RESET = '{present: 1'b0, enable: 1'b0,
		prio: PRIORITY_RESET, count: 32'd0};

endpackage

### design/idac_row_mem.sv
// ----------------------------------------------------------------------------
// Per-line row memory
// Synchronous registered read; per-entry valid bits stand in for the reset fill.
// ----------------------------------------------------------------------------
module idac_row_mem (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [idac_pkg::IDX_W-1:0]    rd_addr,
	output idac_pkg::row_t                rd_row,
	input  idac_pkg::row_wr_t             wr
);

	idac_pkg::row_t                  mem_q [idac_pkg::LINE_COUNT];
	logic [idac_pkg::LINE_COUNT-1:0] vld_q;
	idac_pkg::row_t                  rdata_q;
	logic                            rvld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.row;
		end
		if (rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rvld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_row = rvld_q ? rdata_q : idac_pkg::ROW_RESET;

endmodule

### design/idac_lat_conv.sv
// ----------------------------------------------------------------------------
// Latency converter
// Two-stage cycles-to-microseconds conversion by reciprocal multiply.
// ----------------------------------------------------------------------------
module idac_lat_conv (
	input  logic        clk,
	input  logic        load_in,
	input  logic [31:0] cycles,
	input  logic        load_mul,
	output logic [31:0] us
);

	logic [31:0]                  x;
	logic [idac_pkg::LAT_Y_W-1:0] y_s1;
	logic [63:0]                  prod;
	logic [31:0]                  us_s2;

	assign x    = (cycles << idac_pkg::LAT_SCALE_SHIFT) + idac_pkg::LAT_BIAS;
	assign prod = 64'(y_s1) * 64'(idac_pkg::LAT_RECIP);

	always_ff @(posedge clk) begin
		if (load_in) begin
			y_s1 <= x[31:idac_pkg::LAT_PRE_SHIFT];
		end
		if (load_mul) begin
			us_s2 <= 32'(prod >> idac_pkg::LAT_RECIP_SHIFT);
		end
	end

	assign us = us_s2;

endmodule

### design/interrupt_dispatch_accounting.sv
// ----------------------------------------------------------------------------
// Interrupt dispatch accounting
// Per-line handler, enable, priority and handled-count bookkeeping with
// spurious/unhandled totals and worst dispatch latency.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one command item (register, enable,
//   disable, dispatch, query); out_valid/out_ready/out_data return exactly
//   one result item per command.
//   An item passes these steps from acceptance to out_valid: accept and
//   row read, then read-modify-write of the line's row plus the latency
//   multiply, then the peak compare into the output register.
//   No new item is taken during an item's row read-modify-write; the
//   next item is taken in the final cycle once the output register frees.
//   Reset clears all counters and per-line valid bits at once; rows that
//   were never written read as disabled, no handler, priority 0xA0, count 0.
//   A stalled receiver holds the result in the output register; one more
//   item is accepted and processed up to the final cycle, then in_ready
//   stays low until the output register frees.
// ----------------------------------------------------------------------------
module interrupt_dispatch_accounting (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  idac_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output idac_pkg::out_item_t out_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0] state_q;
	logic       in_acc;
	logic       out_free;

	logic [2:0]                    op_s1;
	logic [idac_pkg::LINE_W-1:0]   line_s1;
	logic                          hvalid_s1;
	logic [7:0]                    prio_s1;
	logic [idac_pkg::ACK_W-1:0]    ack_s1;
	logic [idac_pkg::IDX_W-1:0]    addr_s1;

	logic                          acc_s2;
	logic [1:0]                    outcome_s2;
	logic [idac_pkg::LINE_W-1:0]   subject_s2;
	logic [idac_pkg::ACK_W-1:0]    eoi_s2;
	logic                          en_s2;
	logic [7:0]                    prio_s2;
	logic [31:0]                   cnt_s2;
	logic                          lat_en_s2;

	logic [31:0] unh_q;
	logic [31:0] spur_q;
	logic [31:0] peak_q;
	logic [31:0] new_peak;
	logic [31:0] lat_us;

	idac_pkg::out_item_t out_q;
	logic                out_valid_q;

	idac_pkg::row_t    rd_row;
	idac_pkg::row_wr_t wr;
	logic [idac_pkg::IDX_W-1:0] rd_addr;

	logic [idac_pkg::LINE_W-1:0] subject;
	logic                        in_range;
	logic                        accepted;
	logic [1:0]                  outcome;
	logic [idac_pkg::ACK_W-1:0]  eoi;
	logic                        lat_en;
	logic                        unh_inc;
	logic                        spur_inc;
	idac_pkg::row_t              nrow;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) || ((state_q == ST_FIN) && out_free);
	assign in_acc   = in_valid && in_ready;
	assign rd_addr  = (in_data.op == idac_pkg::OP_DISPATCH) ?
		in_data.acknowledge[idac_pkg::IDX_W-1:0] : in_data.line[idac_pkg::IDX_W-1:0];

	idac_row_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_acc),
		.rd_addr (rd_addr),
		.rd_row  (rd_row),
		.wr      (wr)
	);

	idac_lat_conv u_lat (
		.clk      (clk),
		.load_in  (in_acc),
		.cycles   (in_data.elapsed_cycles),
		.load_mul (state_q == ST_EXEC),
		.us       (lat_us)
	);

	always_comb begin
		subject  = (op_s1 == idac_pkg::OP_DISPATCH) ?
			ack_s1[idac_pkg::LINE_W-1:0] : line_s1;
		in_range = subject < idac_pkg::LINE_LIMIT;
		nrow     = rd_row;
		accepted = 1'b0;
		outcome  = idac_pkg::OUT_NONE;
		eoi      = '0;
		lat_en   = 1'b0;
		unh_inc  = 1'b0;
		spur_inc = 1'b0;
		wr.en    = 1'b0;
		case (op_s1) inside
			idac_pkg::OP_REGISTER: begin
				if (in_range && hvalid_s1 && (line_s1 >= idac_pkg::FIRST_REGISTRABLE)) begin
					nrow.enable  = 1'b0;
					nrow.present = 1'b1;
					nrow.prio    = prio_s1;
					accepted     = 1'b1;
					wr.en        = 1'b1;
				end
			end
			idac_pkg::OP_ENABLE, idac_pkg::OP_DISABLE, idac_pkg::OP_QUERY: begin
				if (in_range) begin
					accepted = 1'b1;
					if (op_s1 == idac_pkg::OP_ENABLE) begin
						nrow.enable = 1'b1;
						wr.en       = 1'b1;
					end else if (op_s1 == idac_pkg::OP_DISABLE) begin
						nrow.enable = 1'b0;
						wr.en       = 1'b1;
					end
				end
			end
			idac_pkg::OP_DISPATCH: begin
				if (subject >= idac_pkg::SPURIOUS_FIRST) begin
					spur_inc = 1'b1;
					outcome  = idac_pkg::OUT_SPURIOUS;
				end else begin
					if (in_range && rd_row.present) begin
						nrow.count = rd_row.count + 32'd1;
						wr.en      = 1'b1;
						outcome    = idac_pkg::OUT_HANDLED;
					end else begin
						unh_inc = 1'b1;
						outcome = idac_pkg::OUT_UNHANDLED;
						if (in_range) begin
							nrow.enable = 1'b0;
							wr.en       = 1'b1;
						end
					end
					eoi    = ack_s1;
					lat_en = 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (state_q != ST_EXEC) begin
			wr.en = 1'b0;
		end
		wr.addr = addr_s1;
		wr.row  = nrow;
	end

	assign new_peak = (lat_en_s2 && (lat_us > peak_q)) ? lat_us : peak_q;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1     <= in_data.op;
			line_s1   <= in_data.line;
			hvalid_s1 <= in_data.handler_valid;
			prio_s1   <= in_data.priority_req;
			ack_s1    <= in_data.acknowledge;
			addr_s1   <= rd_addr;
		end
		if (state_q == ST_EXEC) begin
			acc_s2     <= accepted;
			outcome_s2 <= outcome;
			subject_s2 <= subject;
			eoi_s2     <= eoi;
			en_s2      <= in_range ? nrow.enable : 1'b0;
			prio_s2    <= in_range ? nrow.prio : 8'd0;
			cnt_s2     <= in_range ? nrow.count : 32'd0;
			lat_en_s2  <= lat_en;
		end
		if ((state_q == ST_FIN) && out_free) begin
			out_q.accepted         <= acc_s2;
			out_q.outcome          <= outcome_s2;
			out_q.line_out         <= subject_s2;
			out_q.eoi_word         <= eoi_s2;
			out_q.line_enabled_out <= en_s2;
			out_q.priority_out     <= prio_s2;
			out_q.handled_total    <= cnt_s2;
			out_q.unhandled_total  <= unh_q;
			out_q.spurious_total   <= spur_q;
			out_q.worst_latency_us <= new_peak;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			unh_q       <= '0;
			spur_q      <= '0;
			peak_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (unh_inc) begin
						unh_q <= unh_q + 32'd1;
					end
					if (spur_inc) begin
						spur_q <= spur_q + 32'd1;
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						peak_q      <= new_peak;
						out_valid_q <= 1'b1;
						state_q     <= in_acc ? ST_EXEC : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### design/idac_chk.sv
// ----------------------------------------------------------------------------
// Interrupt dispatch accounting checker
// Port-level assertions on the block's handshakes and result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "interrupt_dispatch_accounting_macros.svh"

module idac_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input idac_pkg::out_item_t out_data
);

	logic in_acc;
	logic out_stall;
	logic out_disp;
	logic out_spur;
	logic spur_ok;

	assign in_acc    = in_valid && in_ready;
	assign out_stall = out_valid && !out_ready;
	assign out_disp  = out_valid && (out_data.outcome != idac_pkg::OUT_NONE);
	assign out_spur  = out_valid && (out_data.outcome == idac_pkg::OUT_SPURIOUS);
	assign spur_ok   = (out_data.eoi_word == '0) &&
		(out_data.line_out >= idac_pkg::SPURIOUS_FIRST);

	`IDAC_ASSERT_NEXT(a_hold, clk, arst_n, out_stall, out_valid && $stable(out_data), "result not held")

	`IDAC_ASSERT_NEXT(a_one_item, clk, arst_n, in_acc, !in_ready, "item accepted while busy")

	`IDAC_ASSERT_SAME(a_disp_acc, clk, arst_n, out_disp, !out_data.accepted, "dispatch flagged accepted")

	`IDAC_ASSERT_SAME(a_spur_shape, clk, arst_n, out_spur, spur_ok, "bad spurious result")

endmodule

bind interrupt_dispatch_accounting idac_chk u_idac_chk (.*);
